// ===== hdl/bswu_pkg.sv =====
// ----------------------------------------------------------------------------
// bswu_pkg
// Types and constants shared by the byte stream to word unpacker.
// ----------------------------------------------------------------------------
package bswu_pkg;

	localparam int ELEM_W = 63;
	localparam int KCFG_W = 6;
	localparam int CNT_W  = 7;

	localparam logic [KCFG_W-1:0] BPE_RESET = 6'd16;

	typedef logic [KCFG_W-1:0] cfg_word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_final;
		logic [3:0] final_valid_bits;
	} in_item_t;

	typedef struct packed {
		logic [ELEM_W-1:0] element_value;
		logic              is_last;
	} out_item_t;

	// byte after masking, with its count of valid bits
	typedef struct packed {
		logic       valid;
		logic [7:0] bits;
		logic [3:0] nbits;
		logic       fin;
	} stage_t;

endpackage

// ===== hdl/bswu_stream_if.sv =====
// ----------------------------------------------------------------------------
// bswu_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bswu_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/bswu_in_stage.sv =====
// ----------------------------------------------------------------------------
// bswu_in_stage
// Input register: masks the byte to its valid bits and holds it until the
// accumulator takes it.
// ----------------------------------------------------------------------------
module bswu_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	bswu_stream_if.sink    in_ch,
	input  logic           take,
	output bswu_pkg::stage_t stage
);
	import bswu_pkg::*;

	logic       v_s1;
	logic [7:0] bits_s1;
	logic [3:0] nbits_s1;
	logic       fin_s1;
	logic [3:0] n_d;
	logic       accept;

	assign in_ch.ready = !v_s1 || take;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		n_d = 4'd8;
		if (in_ch.payload.is_final && in_ch.payload.final_valid_bits < 4'd8) begin
			n_d = in_ch.payload.final_valid_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (take) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bits_s1  <= in_ch.payload.data_byte & ~(8'hFF << n_d);
			nbits_s1 <= n_d;
			fin_s1   <= in_ch.payload.is_final;
		end
	end

	assign stage = '{valid: v_s1, bits: bits_s1, nbits: nbits_s1, fin: fin_s1};

endmodule

// ===== hdl/bswu_core.sv =====
// ----------------------------------------------------------------------------
// bswu_core
// Bit accumulator and result register: appends bytes above held bits and emits
// one K-bit word per cycle unless stalled, then the zero-padded remainder.
// ----------------------------------------------------------------------------
module bswu_core #(
	parameter int MAX_ELEMENT_BITS = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	bswu_stream_if.sink       cfg_ch,
	input  bswu_pkg::stage_t  stage,
	output logic              take,
	bswu_stream_if.source     out_ch
);
	import bswu_pkg::*;

	localparam int ACC_W = MAX_ELEMENT_BITS + 7;

	logic [KCFG_W-1:0] k_q;
	logic [KCFG_W-1:0] k_eff;
	logic [CNT_W-1:0]  k7;
	logic [ACC_W-1:0]  acc_q, acc_a, acc_d;
	logic [CNT_W-1:0]  cnt_q, cnt_a, cnt_d;
	logic              flush_q, flush_d;
	logic              out_v_q;
	out_item_t         out_q;
	logic              out_free, emit_word, emit_flush, last_word;
	logic [ELEM_W-1:0] word;
	logic              cfg_wr;

	assign cfg_ch.ready = 1'b1;
	assign cfg_wr       = cfg_ch.valid;

	always_comb begin
		k_eff = k_q;
		if (k_q == '0) begin
			k_eff = KCFG_W'(1);
		end else if (k_q > KCFG_W'(MAX_ELEMENT_BITS)) begin
			k_eff = KCFG_W'(MAX_ELEMENT_BITS);
		end
	end
	assign k7 = CNT_W'(k_eff);

	assign out_free   = !out_v_q || out_ch.ready;
	assign emit_word  = out_free && (cnt_q >= k7);
	assign emit_flush = out_free && flush_q && (cnt_q != '0) && (cnt_q < k7);
	assign last_word  = flush_q && (cnt_q == k7);
	assign word       = ELEM_W'(acc_q[MAX_ELEMENT_BITS-1:0]) & ~({ELEM_W{1'b1}} << k_eff);

	always_comb begin
		acc_a   = acc_q;
		cnt_a   = cnt_q;
		flush_d = flush_q;
		if (emit_word) begin
			acc_a = acc_q >> k_eff;
			cnt_a = cnt_q - k7;
			if (last_word) begin
				flush_d = 1'b0;
			end
		end
		if (emit_flush || (flush_q && cnt_q == '0)) begin
			acc_a   = '0;
			cnt_a   = '0;
			flush_d = 1'b0;
		end
		take  = stage.valid && !flush_q && (cnt_a < k7);
		acc_d = acc_a;
		cnt_d = cnt_a;
		if (take) begin
			acc_d   = acc_a | (ACC_W'(stage.bits) << cnt_a);
			cnt_d   = cnt_a + CNT_W'(stage.nbits);
			flush_d = stage.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= BPE_RESET;
			acc_q   <= '0;
			cnt_q   <= '0;
			flush_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				k_q     <= cfg_ch.payload;
				acc_q   <= '0;
				cnt_q   <= '0;
				flush_q <= 1'b0;
			end else begin
				acc_q   <= acc_d;
				cnt_q   <= cnt_d;
				flush_q <= flush_d;
			end
			if (emit_word || emit_flush) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_word || emit_flush) begin
			out_q.element_value <= word;
			out_q.is_last       <= emit_flush || last_word;
		end
	end

	assign out_ch.valid   = out_v_q;
	assign out_ch.payload = out_q;

endmodule

// ===== hdl/byte_stream_to_word_unpacker_top.sv =====
// Path: input register, accumulator, result register. Throughput: one byte per
// cycle while K is 8 or more and the output is free; the accumulator gives one
// word per cycle, so for K below 8 or after a final byte, input waits on it.
// Reset clears the held bits and the pipeline and sets the word width to 16.
// ----------------------------------------------------------------------------
// byte_stream_to_word_unpacker_top
// Repacks a byte stream, least significant bit first, into K-bit words.
// ----------------------------------------------------------------------------
module byte_stream_to_word_unpacker_top #(
	parameter int MAX_ELEMENT_BITS = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	bswu_stream_if.sink   cfg_ch,
	bswu_stream_if.sink   in_ch,
	bswu_stream_if.source out_ch
);
	import bswu_pkg::*;

	stage_t stage;
	logic   take;

	bswu_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.take   (take),
		.stage  (stage)
	);

	bswu_core #(
		.MAX_ELEMENT_BITS (MAX_ELEMENT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.stage  (stage),
		.take   (take),
		.out_ch (out_ch)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the byte stream to word unpacker against a cycle-free predictor:
// directed edge cases at the reset width, then random bitstrings across a
// range of word widths with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

	import bswu_pkg::*;

	localparam int MAX_ELEMENT_BITS = 63;
	localparam int STALL_LIMIT      = 1000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int PHASE_ITEMS      = 19;

	logic clk;
	logic arst_n;

	bswu_stream_if #(.payload_t(cfg_word_t)) cfg_ch ();
	bswu_stream_if #(.payload_t(in_item_t))  in_ch ();
	bswu_stream_if #(.payload_t(out_item_t)) out_ch ();

	byte_stream_to_word_unpacker_top #(
		.MAX_ELEMENT_BITS(MAX_ELEMENT_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg_ch(cfg_ch),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	in_item_t    bytes_to_send[$];
	out_item_t   expected_words[$];

	cfg_word_t   word_width;
	logic [71:0] held_bits;
	int unsigned held_count;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        in_taken;
	int unsigned idle_cycles;
	int unsigned error_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// expected words for one accepted byte
	task automatic unpack_byte(input in_item_t it);
		int unsigned k;
		int unsigned n;
		int unsigned produced;
		logic [8:0]  mask;
		logic [71:0] incoming;
		logic [71:0] word_bits;
		out_item_t   w;
		k = word_width;
		if (k == 0)
			k = 1;
		if (k > MAX_ELEMENT_BITS)
			k = MAX_ELEMENT_BITS;
		n = 8;
		if (it.is_final)
			n = (it.final_valid_bits > 4'd8) ? 8 : it.final_valid_bits;
		mask = (9'd1 << n) - 9'd1;
		incoming = {64'd0, it.data_byte & mask[7:0]};
		held_bits = held_bits | (incoming << held_count);
		held_count = held_count + n;
		produced = 0;
		while (held_count >= k && produced < 8) begin
			word_bits = held_bits & ((72'd1 << k) - 72'd1);
			w.element_value = word_bits[ELEM_W-1:0];
			w.is_last = 1'b0;
			expected_words = {expected_words, w};
			held_bits = held_bits >> k;
			held_count = held_count - k;
			produced++;
		end
		if (it.is_final) begin
			if (held_count > 0 && produced < 8) begin
				w.element_value = held_bits[ELEM_W-1:0];
				w.is_last = 1'b0;
				expected_words = {expected_words, w};
				produced++;
			end
			if (produced > 0) begin
				w = expected_words.pop_back();
				w.is_last = 1'b1;
				expected_words = {expected_words, w};
			end
			held_bits = '0;
			held_count = 0;
		end
	endtask

	// monitor and predictor
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			idle_cycles = 0;
			word_width = BPE_RESET;
			held_bits = '0;
			held_count = 0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready) begin
				word_width = cfg_ch.payload;
				held_bits = '0;
				held_count = 0;
			end
			if (in_ch.valid && in_ch.ready)
				unpack_byte(in_ch.payload);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: element_value %h, is_last %b",
						out_ch.payload.element_value, out_ch.payload.is_last);
					error_count++;
				end else begin
					out_item_t exp_word;
					exp_word = expected_words.pop_front();
					if (out_ch.payload.element_value !== exp_word.element_value) begin
						$error("element_value: expected %h, got %h",
							exp_word.element_value, out_ch.payload.element_value);
						error_count++;
					end
					if (out_ch.payload.is_last !== exp_word.is_last) begin
						$error("is_last: expected %b, got %b",
							exp_word.is_last, out_ch.payload.is_last);
						error_count++;
					end
				end
			end
			if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
				(out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_taken) begin
			if (bytes_to_send.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				in_ch.payload <= bytes_to_send.pop_front();
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// word sink
	always @(negedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99, 0) >= recv_stall_pct);
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	task automatic queue_byte(input logic [7:0] data, input logic fin, input logic [3:0] nvalid);
		in_item_t it;
		it.data_byte = data;
		it.is_final = fin;
		it.final_valid_bits = nvalid;
		bytes_to_send = {bytes_to_send, it};
	endtask

	// mostly complete bitstrings, some stray bytes; may stop mid-stream
	task automatic queue_streams(input int unsigned n_items);
		int unsigned added;
		int unsigned len;
		added = 0;
		while (added < n_items) begin
			if ($urandom_range(9, 0) == 0) begin
				queue_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
					4'($urandom_range(15, 0)));
				added++;
			end else begin
				len = $urandom_range(10, 1);
				for (int i = 0; i < len && added < n_items; i++) begin
					if (i == len - 1)
						queue_byte(8'($urandom_range(255, 0)), 1'b1,
							($urandom_range(4, 0) == 0) ? 4'($urandom_range(15, 0))
								: 4'($urandom_range(8, 1)));
					else
						queue_byte(8'($urandom_range(255, 0)), 1'b0,
							4'($urandom_range(15, 0)));
					added++;
				end
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (bytes_to_send.size() != 0 || in_ch.valid || expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input cfg_word_t w);
		@(negedge clk);
		cfg_ch.payload <= w;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		cfg_word_t widths[8];
		widths = '{6'd1, 6'd63, 6'd0, 6'd7, 6'd8, 6'd9, 6'd31, 6'd5};
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// reset width of 16
		queue_byte(8'hFF, 1'b0, 4'd0);
		queue_byte(8'h00, 1'b0, 4'd15);
		queue_byte(8'hA5, 1'b1, 4'd8);
		queue_byte(8'h5A, 1'b1, 4'd0);
		queue_byte(8'h12, 1'b0, 4'd0);
		queue_byte(8'hFF, 1'b1, 4'd0);
		queue_byte(8'hFF, 1'b1, 4'd15);
		queue_byte(8'hFF, 1'b1, 4'd9);
		queue_byte(8'hFF, 1'b1, 4'd1);
		queue_byte(8'h3C, 1'b0, 4'd3);
		queue_byte(8'hC3, 1'b1, 4'd8);
		queue_byte(8'h80, 1'b0, 4'd0);
		queue_byte(8'h01, 1'b0, 4'd0);
		queue_byte(8'h7F, 1'b1, 4'd7);
		queue_byte(8'h00, 1'b1, 4'd8);
		queue_byte(8'hFF, 1'b0, 4'd0);
		queue_byte(8'hFF, 1'b0, 4'd0);
		queue_byte(8'hFF, 1'b1, 4'd8);
		queue_byte(8'hAA, 1'b0, 4'd0);
		queue_byte(8'h55, 1'b1, 4'd4);
		queue_byte(8'h0F, 1'b0, 4'd0);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			write_width(widths[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			queue_streams(PHASE_ITEMS);
			wait_drained();
		end

		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/bswu_pkg.sv
hdl/bswu_stream_if.sv
hdl/bswu_in_stage.sv
hdl/bswu_core.sv
hdl/byte_stream_to_word_unpacker_top.sv
bench/testbench.sv
